// ----- hw/rtl/qbsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package qbsr_pkg;

	// request kinds on the input tuser bit
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	// configuration register indexes
	localparam logic CFG_FRAME_WIDTH = 1'b0;
	localparam logic CFG_DRAW_COLOR  = 1'b1;

	localparam logic [12:0] FRAME_WIDTH_RST = 13'd640;

	// sequencer states
	typedef enum logic [8:0] {
		F_WAIT  = 9'b000000001,
		F_SETUP = 9'b000000010,
		F_ADDR  = 9'b000000100,
		F_EMIT  = 9'b000001000,
		F_CX    = 9'b000010000,
		F_CY    = 9'b000100000,
		F_CHK   = 9'b001000000,
		F_LINIT = 9'b010000000,
		F_LSTEP = 9'b100000000
	} fsm_t;

	// drawing phase
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_CURVE = 3'b010,
		PH_LINE  = 3'b100
	} phase_t;

	// setup steps, named after the product issued in that step or, for SWAP, FLIP and DONE, the action taken
	typedef logic [3:0] setup_step_t;
	localparam setup_step_t SU_XXSX = 4'd0;
	localparam setup_step_t SU_YYSY = 4'd1;
	localparam setup_step_t SU_XXSY = 4'd2;
	localparam setup_step_t SU_YYSX = 4'd3;
	localparam setup_step_t SU_SXSX = 4'd4;
	localparam setup_step_t SU_SYSY = 4'd5;
	localparam setup_step_t SU_XXXX = 4'd6;
	localparam setup_step_t SU_YYYY = 4'd7;
	localparam setup_step_t SU_SWAP = 4'd8;
	localparam setup_step_t SU_XAYA = 4'd9;
	localparam setup_step_t SU_XAXA = 4'd10;
	localparam setup_step_t SU_YAYA = 4'd11;
	localparam setup_step_t SU_FLIP = 4'd12;
	localparam setup_step_t SU_CDX  = 4'd13;
	localparam setup_step_t SU_CDY  = 4'd14;
	localparam setup_step_t SU_DONE = 4'd15;

endpackage
`default_nettype wire

// ----- hw/rtl/qbsr_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qbsr_mul #(
	parameter int AW = 28,
	parameter int BW = 15
) (
	input  wire logic                  clk,
	input  wire logic signed [AW-1:0]  a,
	input  wire logic signed [BW-1:0]  b,
	output logic signed [AW+BW-1:0]    p_q
);
	// shared signed multiplier, product registered
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/quad_bezier_segment_raster_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Quadratic Bezier segment rasterizer. A start request (tuser 0) loads three control
// points; setup runs its steps on one shared registered multiplier, or stops after the
// swap step and adds a line setup step when the curve is degenerate and drawn as a line.
// A start whose gradient changes sign gives one result with tuser 1. Each step request
// (tuser 1) gives one pixel, on the curve by address multiply on the shared unit, output
// load, x update, y update, direction check and optional line setup, on the line part by
// address multiply, output load and line step, and at the end point by address multiply
// and output load; tlast marks the end point. A step while no segment runs gives nothing.
// Input is taken only while the sequencer waits; the result sits in an output
// register and the sequencer stalls at output load until that register is free.
module quad_bezier_segment_raster_top #(
	parameter int COORD_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// start_x, start_y, ctrl_x, ctrl_y, end_x, end_y (12 bits each)
	input  wire logic [71:0] s_tdata,
	// req_type
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// pixel_x (12), pixel_y (12), pixel_addr (24), pixel_color (32)
	output logic [79:0]      m_tdata,
	output logic             m_tlast,
	// bad_segment
	output logic             m_tuser,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	import qbsr_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int MA = 2 * COORD_BITS + 4;
	localparam int MB = (COORD_BITS + 3 > 14) ? COORD_BITS + 3 : 14;

	fsm_t                 fsm_q;
	phase_t               phase_q;
	setup_step_t          st_q;
	logic                 bad_q;
	logic                 ystep_q;
	logic [12:0]          fw_q;
	logic [31:0]          color_q;
	logic [CW-1:0]        x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
	logic [CW-1:0]        cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic                 step_x_neg_q, step_y_neg_q;
	logic signed [63:0]   diff_x_q, diff_y_q, err_q, sxx_q, syy_q, sxy_q;
	logic signed [63:0]   cur_q, t1_q, t2_q;
	logic                 ov_q, o_last_q, o_bad_q;
	logic [11:0]          o_x_q, o_y_q;
	logic [23:0]          o_addr_q;
	logic [31:0]          o_color_q;

	logic signed [MA-1:0]     mul_a;
	logic signed [MB-1:0]     mul_b;
	logic signed [MA+MB-1:0]  mul_p;
	logic signed [63:0]       prod, p4;
	logic signed [MB-1:0]     ux0, uy0, ux1, uy1, ux2, uy2;
	logic signed [MB-1:0]     sx, sy, xx, yy, ex, ey, xa, ya, d10x, d01y;
	logic                     dx_neg, dy_neg;
	logic signed [CW:0]       ldx, ldy, lax, lay;
	logic signed [63:0]       labsx, labsy;
	logic signed [63:0]       tt, cx_dx, cx_dy, cy_dx, cy_dy, l_err;
	logic                     last_px, out_free;

	// setup operands from the captured points
	always_comb begin
		ux0 = signed'(MB'(x0_q));
		uy0 = signed'(MB'(y0_q));
		ux1 = signed'(MB'(x1_q));
		uy1 = signed'(MB'(y1_q));
		ux2 = signed'(MB'(x2_q));
		uy2 = signed'(MB'(y2_q));
		sx = ux2 - ux1;
		sy = uy2 - uy1;
		xx = ux0 - ux1;
		yy = uy0 - uy1;
		ex = xx + sx;
		ey = yy + sy;
		dx_neg = !(x0_q < x2_q);
		dy_neg = !(y0_q < y2_q);
		xa = dx_neg ? -ex : ex;
		ya = dy_neg ? -ey : ey;
		d10x = ux1 - ux0;
		d01y = uy0 - uy1;
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (fsm_q == F_SETUP) begin
			unique case (st_q)
				SU_XXSX: begin mul_a = MA'(xx); mul_b = sx; end
				SU_YYSY: begin mul_a = MA'(yy); mul_b = sy; end
				SU_XXSY: begin mul_a = MA'(xx); mul_b = sy; end
				SU_YYSX: begin mul_a = MA'(yy); mul_b = sx; end
				SU_SXSX: begin mul_a = MA'(sx); mul_b = sx; end
				SU_SYSY: begin mul_a = MA'(sy); mul_b = sy; end
				SU_XXXX: begin mul_a = MA'(xx); mul_b = xx; end
				SU_YYYY: begin mul_a = MA'(yy); mul_b = yy; end
				SU_XAYA: begin mul_a = MA'(xa); mul_b = ya; end
				SU_XAXA: begin mul_a = MA'(xa); mul_b = xa; end
				SU_YAYA: begin mul_a = MA'(ya); mul_b = ya; end
				SU_CDX:  begin mul_a = MA'(cur_q); mul_b = d10x; end
				SU_CDY:  begin mul_a = MA'(cur_q); mul_b = d01y; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (fsm_q == F_ADDR || fsm_q == F_EMIT) begin
			mul_a = signed'(MA'(cur_y_q));
			mul_b = signed'(MB'(fw_q));
		end
	end

	qbsr_mul #(
		.AW(MA),
		.BW(MB)
	) u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p_q(mul_p)
	);

	assign prod = 64'(mul_p);
	assign p4   = {prod[61:0], 2'b00};

	// line setup values from current and goal points
	always_comb begin
		ldx = signed'({1'b0, goal_x_q}) - signed'({1'b0, cur_x_q});
		ldy = signed'({1'b0, goal_y_q}) - signed'({1'b0, cur_y_q});
		lax = (ldx < 0) ? -ldx : ldx;
		lay = (ldy < 0) ? -ldy : ldy;
		labsx = 64'(lax);
		labsy = 64'(lay);
	end

	// per pixel step arithmetic
	always_comb begin
		tt = err_q + err_q;
		cx_dx = diff_x_q - sxy_q;
		cx_dy = diff_y_q + syy_q;
		cy_dy = diff_y_q - sxy_q;
		cy_dx = diff_x_q + sxx_q;
		l_err = err_q + ((tt >= diff_y_q) ? diff_y_q : 64'sd0)
			+ ((tt <= diff_x_q) ? diff_x_q : 64'sd0);
	end

	assign last_px  = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
	assign out_free = !ov_q || m_tready;
	assign s_tready = (fsm_q == F_WAIT);
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= FRAME_WIDTH_RST;
			color_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH: fw_q <= cfg_data[12:0];
				CFG_DRAW_COLOR:  color_q <= cfg_data;
				default:         fw_q <= fw_q;
			endcase
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= F_WAIT;
			phase_q <= PH_IDLE;
			st_q    <= SU_XXSX;
			bad_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			// output register valid flag
			if (fsm_q == F_EMIT && out_free) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			unique case (fsm_q)
				F_WAIT: begin
					if (s_tvalid) begin
						bad_q <= 1'b0;
						if (s_tuser == REQ_START) begin
							st_q  <= SU_XXSX;
							fsm_q <= F_SETUP;
						end else if (phase_q != PH_IDLE) begin
							fsm_q <= F_ADDR;
						end
					end
				end
				F_SETUP: begin
					st_q <= st_q + 4'd1;
					unique case (st_q)
						SU_YYSY: bad_q <= (prod > 0);
						SU_XXSY: begin
							if (bad_q || prod > 0) begin
								bad_q   <= 1'b1;
								phase_q <= PH_IDLE;
								fsm_q   <= F_EMIT;
							end
						end
						SU_SWAP: begin
							if (cur_q == 0) begin
								fsm_q <= F_LINIT;
							end
						end
						SU_DONE: begin
							phase_q <= PH_CURVE;
							fsm_q   <= F_WAIT;
						end
						default: bad_q <= bad_q;
					endcase
				end
				F_ADDR: fsm_q <= F_EMIT;
				F_EMIT: begin
					if (out_free) begin
						if (bad_q) begin
							fsm_q <= F_WAIT;
						end else if (last_px) begin
							phase_q <= PH_IDLE;
							fsm_q   <= F_WAIT;
						end else if (phase_q == PH_CURVE) begin
							fsm_q <= F_CX;
						end else begin
							fsm_q <= F_LSTEP;
						end
					end
				end
				F_CX:    fsm_q <= F_CY;
				F_CY:    fsm_q <= F_CHK;
				F_CHK:   fsm_q <= (diff_y_q < 0 && diff_x_q > 0) ? F_WAIT : F_LINIT;
				F_LINIT: begin
					phase_q <= PH_LINE;
					fsm_q   <= F_WAIT;
				end
				F_LSTEP: fsm_q <= F_WAIT;
				default: fsm_q <= F_WAIT;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (fsm_q)
			F_WAIT: begin
				if (s_tvalid && s_tuser == REQ_START) begin
					x0_q <= CW'({20'd0, s_tdata[11:0]});
					y0_q <= CW'({20'd0, s_tdata[23:12]});
					x1_q <= CW'({20'd0, s_tdata[35:24]});
					y1_q <= CW'({20'd0, s_tdata[47:36]});
					x2_q <= CW'({20'd0, s_tdata[59:48]});
					y2_q <= CW'({20'd0, s_tdata[71:60]});
				end
			end
			F_SETUP: begin
				unique case (st_q)
					SU_YYSX: t1_q <= prod;
					SU_SXSX: cur_q <= t1_q - prod;
					SU_SYSY: t1_q <= prod;
					SU_XXXX: t1_q <= t1_q + prod;
					SU_YYYY: t2_q <= prod;
					SU_SWAP: begin
						// start from the longer part
						if (t1_q > t2_q + prod) begin
							x0_q     <= x2_q;
							y0_q     <= y2_q;
							x2_q     <= x0_q;
							y2_q     <= y0_q;
							cur_x_q  <= x2_q;
							cur_y_q  <= y2_q;
							goal_x_q <= x0_q;
							goal_y_q <= y0_q;
							cur_q    <= -cur_q;
						end else begin
							cur_x_q  <= x0_q;
							cur_y_q  <= y0_q;
							goal_x_q <= x2_q;
							goal_y_q <= y2_q;
						end
					end
					SU_XAXA: sxy_q <= prod + prod;
					SU_YAYA: sxx_q <= prod;
					SU_FLIP: begin
						// curvature sign against step directions
						if ((cur_q < 0) ^ dx_neg ^ dy_neg) begin
							cur_q <= -cur_q;
							sxx_q <= -sxx_q;
							sxy_q <= -sxy_q;
							syy_q <= -prod;
						end else begin
							syy_q <= prod;
						end
					end
					SU_CDY: diff_x_q <= (dy_neg ? -p4 : p4) + sxx_q - sxy_q;
					SU_DONE: begin
						diff_y_q     <= (dx_neg ? -p4 : p4) + syy_q - sxy_q;
						err_q        <= diff_x_q + (dx_neg ? -p4 : p4) + syy_q;
						sxx_q        <= sxx_q + sxx_q;
						syy_q        <= syy_q + syy_q;
						step_x_neg_q <= dx_neg;
						step_y_neg_q <= dy_neg;
					end
					default: t2_q <= t2_q;
				endcase
			end
			F_CX: begin
				ystep_q <= (tt < diff_x_q);
				if (tt > diff_y_q) begin
					cur_x_q  <= step_x_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
					diff_x_q <= cx_dx;
					diff_y_q <= cx_dy;
					err_q    <= err_q + cx_dy;
				end
			end
			F_CY: begin
				if (ystep_q) begin
					cur_y_q  <= step_y_neg_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
					diff_y_q <= cy_dy;
					diff_x_q <= cy_dx;
					err_q    <= err_q + cy_dx;
				end
			end
			F_LINIT: begin
				step_x_neg_q <= !(cur_x_q < goal_x_q);
				step_y_neg_q <= !(cur_y_q < goal_y_q);
				diff_x_q     <= labsx;
				diff_y_q     <= -labsy;
				err_q        <= labsx - labsy;
			end
			F_LSTEP: begin
				err_q <= l_err;
				if (tt >= diff_y_q) begin
					cur_x_q <= step_x_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
				end
				if (tt <= diff_x_q) begin
					cur_y_q <= step_y_neg_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
				end
			end
			default: begin
				ystep_q <= ystep_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (fsm_q == F_EMIT && out_free) begin
			if (bad_q) begin
				o_x_q     <= '0;
				o_y_q     <= '0;
				o_addr_q  <= '0;
				o_color_q <= '0;
				o_last_q  <= 1'b0;
				o_bad_q   <= 1'b1;
			end else begin
				o_x_q     <= 12'({16'd0, cur_x_q});
				o_y_q     <= 12'({16'd0, cur_y_q});
				o_addr_q  <= prod[23:0] + 24'(cur_x_q);
				o_color_q <= color_q;
				o_last_q  <= last_px;
				o_bad_q   <= 1'b0;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {o_color_q, o_addr_q, o_y_q, o_x_q};
	assign m_tlast  = o_last_q;
	assign m_tuser  = o_bad_q;

`ifndef NO_ASSERTIONS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
		else $error("error result carries pixel data");
	a_cx_curve: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == F_CX |-> phase_q == PH_CURVE)
		else $error("curve step outside curve phase");
	a_lstep_line: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == F_LSTEP |-> phase_q == PH_LINE)
		else $error("line step outside line phase");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == F_EMIT && out_free && !bad_q && last_px |=> phase_q == PH_IDLE)
		else $error("segment still running after end point");
`endif

endmodule
`default_nettype wire

// ----- tb/quad_bezier_segment_raster_top_tb.sv -----
`timescale 1ns / 1ps
module quad_bezier_segment_raster_top_tb;
	import qbsr_pkg::*;

	localparam int CB = 12;
	localparam longint LIMIT = 2000000;

	// ordered as the result bus, color at the top down to the error flag
	typedef struct packed {
		logic [31:0] color;
		logic [23:0] addr;
		logic [11:0] y;
		logic [11:0] x;
		logic        last;
		logic        bad;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	quad_bezier_segment_raster_top dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [12:0]    width_q;
	logic [31:0]    color_q;
	phase_t         ph;
	logic [CB-1:0]  cx, cy, gx, gy;
	logic           nx, ny;
	longint         ddx, ddy, acc, sxx, syy, sxy;

	pixel_t pixel_fifo[$];
	int     errors = 0;
	int     mism = 0;
	longint cycles = 0;
	bit     hold_rx = 0;
	int     burst_left = 0;

	function automatic pixel_t make_pixel(logic [CB-1:0] x, logic [CB-1:0] y, logic l);
		pixel_t p;
		p.x = x;
		p.y = y;
		p.addr = 24'(longint'(y) * longint'(width_q) + longint'(x));
		p.color = color_q;
		p.last = l;
		p.bad = 1'b0;
		return p;
	endfunction

	function automatic logic [CB-1:0] stepc(logic [CB-1:0] c, logic neg);
		return neg ? c - CB'(1) : c + CB'(1);
	endfunction

	function automatic void to_line();
		longint dx, dy;
		dx = longint'(gx) - longint'(cx);
		dy = longint'(gy) - longint'(cy);
		nx = !(cx < gx);
		ny = !(cy < gy);
		ddx = dx < 0 ? -dx : dx;
		ddy = dy < 0 ? dy : -dy;
		acc = ddx + ddy;
		ph = PH_LINE;
	endfunction

	// load a segment, queue the error result when the gradient changes sign
	function automatic void load_segment(logic [71:0] d);
		longint x0, y0, x1, y1, x2, y2, sx, sy, xx, yy, cu, xy, dirx, diry;
		pixel_t p;
		x0 = d[11:0]; y0 = d[23:12]; x1 = d[35:24];
		y1 = d[47:36]; x2 = d[59:48]; y2 = d[71:60];
		sx = x2 - x1; sy = y2 - y1; xx = x0 - x1; yy = y0 - y1;
		if (xx * sx > 0 || yy * sy > 0) begin
			ph = PH_IDLE;
			p = '0;
			p.bad = 1'b1;
			pixel_fifo.push_back(p);
			return;
		end
		cu = xx * sy - yy * sx;
		if (sx * sx + sy * sy > xx * xx + yy * yy) begin
			x2 = x0; x0 = sx + x1;
			y2 = y0; y0 = sy + y1;
			cu = -cu;
		end
		cx = x0[CB-1:0]; cy = y0[CB-1:0]; gx = x2[CB-1:0]; gy = y2[CB-1:0];
		if (cu == 0) begin
			to_line();
			return;
		end
		dirx = x0 < x2 ? 1 : -1;
		diry = y0 < y2 ? 1 : -1;
		xx = (xx + sx) * dirx;
		yy = (yy + sy) * diry;
		xy = 2 * xx * yy;
		xx = xx * xx;
		yy = yy * yy;
		if (cu * dirx * diry < 0) begin
			xx = -xx; yy = -yy; xy = -xy; cu = -cu;
		end
		ddx = 4 * diry * cu * (x1 - x0) + xx - xy;
		ddy = 4 * dirx * cu * (y0 - y1) + yy - xy;
		sxx = xx + xx; syy = yy + yy; sxy = xy;
		acc = ddx + ddy + xy;
		nx = dirx < 0;
		ny = diry < 0;
		ph = PH_CURVE;
	endfunction

	function automatic void advance_pixel();
		logic   l, ys;
		longint t;
		if (ph == PH_IDLE) return;
		l = (cx == gx) && (cy == gy);
		pixel_fifo.push_back(make_pixel(cx, cy, l));
		if (l) begin
			ph = PH_IDLE;
			return;
		end
		t = acc + acc;
		if (ph == PH_CURVE) begin
			ys = t < ddx;
			if (t > ddy) begin
				cx = stepc(cx, nx); ddx -= sxy; ddy += syy; acc += ddy;
			end
			if (ys) begin
				cy = stepc(cy, ny); ddy -= sxy; ddx += sxx; acc += ddx;
			end
			if (!(ddy < 0 && ddx > 0)) to_line();
		end else begin
			if (t >= ddy) begin
				acc += ddy; cx = stepc(cx, nx);
			end
			if (t <= ddx) begin
				acc += ddx; cy = stepc(cy, ny);
			end
		end
	endfunction

	// send one request, with bursts and random gaps
	task automatic send_request(logic kind, logic [71:0] d);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 2) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		if (kind == REQ_START) load_segment(d);
		else advance_pixel();
	endtask

	function automatic logic [71:0] pack_pts(int x0, int y0, int x1, int y1, int x2, int y2);
		return {12'(y2), 12'(x2), 12'(y1), 12'(x1), 12'(y0), 12'(x0)};
	endfunction

	// draw until the end pixel, with a cap on steps
	task automatic draw_segment(logic [71:0] d, int cap);
		send_request(REQ_START, d);
		for (int i = 0; i < cap && ph != PH_IDLE; i++) send_request(REQ_STEP, '0);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pixel_fifo.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_FRAME_WIDTH) width_q = v[12:0];
		else color_q = v;
	endtask

	// random monotone segment: middle point between both ends in x and in y
	function automatic logic [71:0] rand_monotone(int span);
		int x1, y1, ax, ay, bx, by, sgx, sgy;
		x1 = $urandom_range(0, 4095);
		y1 = $urandom_range(0, 4095);
		sgx = $urandom_range(0, 1) ? 1 : -1;
		sgy = $urandom_range(0, 1) ? 1 : -1;
		ax = x1 + sgx * $urandom_range(0, span);
		bx = x1 - sgx * $urandom_range(0, span);
		ay = y1 + sgy * $urandom_range(0, span);
		by = y1 - sgy * $urandom_range(0, span);
		if (ax < 0 || ax > 4095 || bx < 0 || bx > 4095) begin
			x1 = 2048; ax = x1 + sgx * span / 2; bx = x1 - sgx * span / 3;
		end
		if (ay < 0 || ay > 4095 || by < 0 || by > 4095) begin
			y1 = 2048; ay = y1 - sgy * span / 3; by = y1 + sgy * span / 2;
		end
		// pair the ends crosswise; the middle point stays between the ends in each coordinate
		return pack_pts(ax, by, x1, y1, bx, ay);
	endfunction

	task automatic test_directed();
		send_request(REQ_STEP, '0);
		draw_segment(pack_pts(0, 0, 0, 20, 20, 20), 200);
		draw_segment(pack_pts(20, 20, 20, 0, 0, 0), 200);
		draw_segment(pack_pts(4095, 4095, 4095, 4085, 4080, 4085), 200);
		draw_segment(pack_pts(5, 5, 10, 10, 15, 15), 200);
		draw_segment(pack_pts(100, 7, 100, 7, 100, 7), 5);
		draw_segment(pack_pts(0, 0, 10, 0, 40, 0), 60);
		send_request(REQ_START, pack_pts(0, 0, 10, 10, 20, 20));
		send_request(REQ_START, pack_pts(0, 0, 10, 10, 20, 0));
		send_request(REQ_START, pack_pts(4095, 4095, 0, 0, 4095, 4095));
		draw_segment(pack_pts(0, 4095, 0, 0, 4095, 0), 3);
		draw_segment(pack_pts(3, 3, 0, 0, 6, 0), 40);
		send_request(REQ_STEP, '0);
		draw_segment(pack_pts(0, 1, 0, 0, 1, 0), 10);
	endtask

	task automatic test_random(int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			case ($urandom_range(0, 9))
				0: begin
					send_request(REQ_START, 72'({$urandom, $urandom, $urandom}));
					sent++;
				end
				1: begin
					send_request(REQ_STEP, 72'({$urandom, $urandom, $urandom}));
					sent++;
				end
				default: begin
					send_request(REQ_START, rand_monotone(
						$urandom_range(0, 9) == 0 ? 2000 : 12));
					sent++;
					for (int i = 0; i < 60 && ph != PH_IDLE; i++) begin
						send_request(REQ_STEP, 72'({$urandom, $urandom, $urandom}));
						sent++;
					end
				end
			endcase
		end
	endtask

	task automatic test_backpressure();
		hold_rx = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end
			draw_segment(pack_pts(0, 0, 0, 30, 30, 30), 40);
		join
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (hold_rx) m_tready <= 1'b0;
		else if (cycles[9:8] == 2'b11) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// compare each result with the oldest expected one
	always @(posedge clk) begin
		pixel_t got, exp_p;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata, m_tlast, m_tuser};
			if (pixel_fifo.size() == 0) begin
				errors++;
				if (mism < 10) $display("unexpected result %h", got);
				mism++;
			end else begin
				exp_p = pixel_fifo.pop_front();
				if (got !== exp_p) begin
					errors++;
					if (mism < 10) $display("mismatch exp %p got %p", exp_p, got);
					mism++;
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		width_q = FRAME_WIDTH_RST;
		color_q = '0;
		ph = PH_IDLE;
		cx = '0; cy = '0; gx = '0; gy = '0; nx = 0; ny = 0;
		ddx = 0; ddy = 0; acc = 0; sxx = 0; syy = 0; sxy = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		drain();
		write_reg(CFG_FRAME_WIDTH, 32'd1);
		write_reg(CFG_DRAW_COLOR, 32'hFFFF_FFFF);
		test_random(50);
		test_backpressure();
		drain();
		write_reg(CFG_FRAME_WIDTH, 32'd4096);
		write_reg(CFG_DRAW_COLOR, 32'h0);
		test_random(50);
		drain();
		write_reg(CFG_FRAME_WIDTH, 32'd0);
		write_reg(CFG_DRAW_COLOR, $urandom);
		test_directed();
		drain();
		write_reg(CFG_FRAME_WIDTH, $urandom_range(1, 4096));
		write_reg(CFG_DRAW_COLOR, $urandom);
		test_random(50);
		drain();
		if (errors == 0 && pixel_fifo.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
